// ===== hw/rtl/frm_pkg.sv =====
// ----------------------------------------------------------------------------
// frm_pkg
// shared widths, constants, datapath opcodes and structs of the frame rate meter
// ----------------------------------------------------------------------------
package frm_pkg;

    // frame count width, at most FEXT_W
    localparam int FRAME_COUNT_BITS = 32;

    localparam int TICK_W     = 64;
    localparam int TPS_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int RATE_W     = 10;
    localparam int DIGIT_W    = 4;
    localparam int DCOUNT_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_ENABLE   = CFG_IDX_W'(1);

    localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(19200000);
    localparam logic [RATE_W-1:0] RATE_MAX  = RATE_W'(999);

    // multiplier split: frame count extended to FEXT_W, two halves
    localparam int FEXT_W   = 48;
    localparam int MUL_HALF = FEXT_W / 2;
    localparam int PP_W     = MUL_HALF + TPS_W;
    localparam int PROD_W   = FEXT_W + TPS_W;

    // divider: quotient bits kept before saturation
    localparam int QUO_W   = 10;
    localparam int QRND_W  = QUO_W + 1;
    localparam int REM_W   = TICK_W + QUO_W;
    localparam int SHIFT_W = $clog2(QUO_W);

    // decimal split by reciprocal multiplication
    localparam int HP_W       = 16;
    localparam int TP_W       = 14;
    localparam int SUB_W      = 7;
    localparam int HUND_SHIFT = 12;
    localparam int TENS_SHIFT = 10;
    localparam logic [HP_W-1:0]   HUND_RECIP = HP_W'(41);
    localparam logic [TP_W-1:0]   TENS_RECIP = TP_W'(103);
    localparam logic [RATE_W-1:0] DEC_100    = RATE_W'(100);
    localparam logic [RATE_W-1:0] DEC_10     = RATE_W'(10);
    localparam logic [SUB_W-1:0]  DEC_10_S   = SUB_W'(10);

    localparam logic [DCOUNT_W-1:0] DCOUNT_ONE   = DCOUNT_W'(1);
    localparam logic [DCOUNT_W-1:0] DCOUNT_TWO   = DCOUNT_W'(2);
    localparam logic [DCOUNT_W-1:0] DCOUNT_THREE = DCOUNT_W'(3);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ELAPSED,
        OP_COMPARE,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_MUL_SUM,
        OP_OVF_CHK,
        OP_DIV_STEP,
        OP_ROUND,
        OP_COMMIT,
        OP_HUND,
        OP_REM,
        OP_TENS,
        OP_ONES,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op               op;
        logic [SHIFT_W-1:0]   div_shift;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
        logic elapsed_zero;
    } t_dp_status;

    typedef struct packed {
        logic [RATE_W-1:0]   frame_rate;
        logic [DIGIT_W-1:0]  digit_hundreds;
        logic [DIGIT_W-1:0]  digit_tens;
        logic [DIGIT_W-1:0]  digit_ones;
        logic [DCOUNT_W-1:0] digit_count;
        logic                rate_updated;
        logic                overlay_shown;
    } t_result;

endpackage

// ===== hw/rtl/frm_frame_if.sv =====
// ----------------------------------------------------------------------------
// frm_frame_if
// frame present channel: valid, ready and the present tick
// ----------------------------------------------------------------------------
interface frm_frame_if import frm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] present_tick;

    modport source (output valid, output present_tick, input ready);
    modport sink   (input valid, input present_tick, output ready);
endinterface

// ===== hw/rtl/frm_rate_if.sv =====
// ----------------------------------------------------------------------------
// frm_rate_if
// rate readout channel: valid, ready and the result fields
// ----------------------------------------------------------------------------
interface frm_rate_if import frm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RATE_W-1:0]   frame_rate;
    logic [DIGIT_W-1:0]  digit_hundreds;
    logic [DIGIT_W-1:0]  digit_tens;
    logic [DIGIT_W-1:0]  digit_ones;
    logic [DCOUNT_W-1:0] digit_count;
    logic                rate_updated;
    logic                overlay_shown;

    modport source (
        output valid, output frame_rate, output digit_hundreds, output digit_tens,
        output digit_ones, output digit_count, output rate_updated, output overlay_shown,
        input ready
    );
    modport sink (
        input valid, input frame_rate, input digit_hundreds, input digit_tens,
        input digit_ones, input digit_count, input rate_updated, input overlay_shown,
        output ready
    );
endinterface

// ===== hw/rtl/frm_datapath.sv =====
// ----------------------------------------------------------------------------
// frm_datapath
// window state, split multiplier, restoring divider, decimal split, result register
// ----------------------------------------------------------------------------
module frm_datapath import frm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [TICK_W-1:0]     i_present_tick,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output t_result               o_result
);

    // state with reset
    logic [TPS_W-1:0]            r_tps;
    logic                        r_overlay;
    logic                        r_seeded;
    logic [TICK_W-1:0]           r_window_start;
    logic [FRAME_COUNT_BITS-1:0] r_frame_count;
    logic [RATE_W-1:0]           r_held_rate;

    // working registers
    logic [TICK_W-1:0]  r_now;
    logic [TICK_W-1:0]  r_elapsed;
    logic               r_close;
    logic               r_ezero;
    logic [PP_W-1:0]    r_pp;
    logic [PROD_W-1:0]  r_prod;
    logic               r_ovf;
    logic [REM_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [RATE_W-1:0]  r_rate_new;
    logic [DIGIT_W-1:0] r_hund;
    logic [SUB_W-1:0]   r_sub;
    logic [DIGIT_W-1:0] r_tens;
    logic [DIGIT_W-1:0] r_ones;
    t_result            r_result;

    logic [FEXT_W-1:0]   f_ext;
    logic [PP_W-1:0]     pp_lo;
    logic [PP_W-1:0]     pp_hi;
    logic [REM_W-1:0]    divisor;
    logic                div_fits;
    logic                ovf;
    logic                round_up;
    logic [QRND_W-1:0]   quo_rnd;
    logic [RATE_W-1:0]   rate_clamp;
    logic [HP_W-1:0]     hund_prod;
    logic [RATE_W-1:0]   rem100;
    logic [TP_W-1:0]     tens_prod;
    logic [SUB_W-1:0]    ones;
    logic [DCOUNT_W-1:0] dcount;

    assign f_ext    = FEXT_W'(r_frame_count);
    assign pp_lo    = PP_W'(f_ext[MUL_HALF-1:0]) * PP_W'(r_tps);
    assign pp_hi    = PP_W'(f_ext[FEXT_W-1:MUL_HALF]) * PP_W'(r_tps);

    assign divisor  = REM_W'(r_elapsed) << i_cmd.div_shift;
    assign div_fits = r_rem >= divisor;
    assign ovf      = r_prod >= (PROD_W'(r_elapsed) << QUO_W);

    // halves round up
    assign round_up   = {r_rem[TICK_W-1:0], 1'b0} >= {1'b0, r_elapsed};
    assign quo_rnd    = {1'b0, r_quo} + QRND_W'(round_up);
    assign rate_clamp = (r_ovf || quo_rnd > QRND_W'(RATE_MAX)) ? RATE_MAX
                                                               : quo_rnd[RATE_W-1:0];

    assign hund_prod = HP_W'(r_held_rate) * HUND_RECIP;
    assign rem100    = r_held_rate - RATE_W'(r_hund) * DEC_100;
    assign tens_prod = TP_W'(r_sub) * TENS_RECIP;
    assign ones      = r_sub - SUB_W'(r_tens) * DEC_10_S;

    always_comb begin
        if (r_held_rate >= DEC_100) begin
            dcount = DCOUNT_THREE;
        end else if (r_held_rate >= DEC_10) begin
            dcount = DCOUNT_TWO;
        end else begin
            dcount = DCOUNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps          <= TPS_RESET;
            r_overlay      <= 1'b0;
            r_seeded       <= 1'b0;
            r_window_start <= '0;
            r_frame_count  <= '0;
            r_held_rate    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == REG_TICKS_PER_SECOND) begin
                    r_tps <= i_cfg_wdata[TPS_W-1:0];
                end else if (i_cfg_idx == REG_OVERLAY_ENABLE) begin
                    r_overlay <= i_cfg_wdata[0];
                end
            end
            if (i_cmd.op == OP_LOAD) begin
                if (!r_seeded) begin
                    r_seeded       <= 1'b1;
                    r_window_start <= i_present_tick;
                    r_frame_count  <= FRAME_COUNT_BITS'(1);
                end else if (r_frame_count != '1) begin
                    r_frame_count <= r_frame_count + FRAME_COUNT_BITS'(1);
                end
            end
            if (i_cmd.op == OP_COMMIT && r_close) begin
                r_held_rate    <= r_ezero ? '0 : r_rate_new;
                r_window_start <= r_now;
                r_frame_count  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD:     r_now <= i_present_tick;
            OP_ELAPSED:  r_elapsed <= r_now - r_window_start;
            OP_COMPARE: begin
                r_close <= r_elapsed >= TICK_W'(r_tps);
                r_ezero <= r_elapsed == '0;
            end
            OP_MUL_LO:   r_pp <= pp_lo;
            OP_MUL_HI: begin
                r_prod <= PROD_W'(r_pp);
                r_pp   <= pp_hi;
            end
            OP_MUL_SUM:  r_prod <= r_prod + (PROD_W'(r_pp) << MUL_HALF);
            OP_OVF_CHK: begin
                r_ovf <= ovf;
                r_rem <= r_prod[REM_W-1:0];
                r_quo <= '0;
            end
            OP_DIV_STEP: begin
                if (div_fits) begin
                    r_rem <= r_rem - divisor;
                end
                r_quo <= {r_quo[QUO_W-2:0], div_fits};
            end
            OP_ROUND:    r_rate_new <= rate_clamp;
            OP_HUND:     r_hund <= hund_prod[HUND_SHIFT +: DIGIT_W];
            OP_REM:      r_sub <= rem100[SUB_W-1:0];
            OP_TENS:     r_tens <= tens_prod[TENS_SHIFT +: DIGIT_W];
            OP_ONES:     r_ones <= ones[DIGIT_W-1:0];
            OP_EMIT: begin
                r_result.frame_rate     <= r_held_rate;
                r_result.digit_hundreds <= r_hund;
                r_result.digit_tens     <= r_tens;
                r_result.digit_ones     <= r_ones;
                r_result.digit_count    <= dcount;
                r_result.rate_updated   <= r_close;
                r_result.overlay_shown  <= r_overlay;
            end
            OP_NONE, OP_COMMIT: ;
            default: ;
        endcase
    end

    assign o_status.close        = r_close;
    assign o_status.elapsed_zero = r_ezero;
    assign o_result              = r_result;

endmodule

// ===== hw/rtl/frm_ctrl.sv =====
// ----------------------------------------------------------------------------
// frm_ctrl
// sequencer for one present: window check, multiply, divide, digits, hand-off
// ----------------------------------------------------------------------------
module frm_ctrl import frm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ELAP,
        S_CMP,
        S_BRANCH,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_SUM,
        S_OVF,
        S_DIV,
        S_ROUND,
        S_COMMIT,
        S_HUND,
        S_REM,
        S_TENS,
        S_ONES,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [SHIFT_W-1:0] r_shift;
    logic               r_out_valid;
    logic               emit_ok;

    assign emit_ok     = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.div_shift = r_shift;
        unique case (r_state)
            S_IDLE:    o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_ELAP:    o_cmd.op = OP_ELAPSED;
            S_CMP:     o_cmd.op = OP_COMPARE;
            S_BRANCH:  o_cmd.op = OP_NONE;
            S_MUL_LO:  o_cmd.op = OP_MUL_LO;
            S_MUL_HI:  o_cmd.op = OP_MUL_HI;
            S_MUL_SUM: o_cmd.op = OP_MUL_SUM;
            S_OVF:     o_cmd.op = OP_OVF_CHK;
            S_DIV:     o_cmd.op = OP_DIV_STEP;
            S_ROUND:   o_cmd.op = OP_ROUND;
            S_COMMIT:  o_cmd.op = OP_COMMIT;
            S_HUND:    o_cmd.op = OP_HUND;
            S_REM:     o_cmd.op = OP_REM;
            S_TENS:    o_cmd.op = OP_TENS;
            S_ONES:    o_cmd.op = OP_ONES;
            S_EMIT:    o_cmd.op = emit_ok ? OP_EMIT : OP_NONE;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_ELAP;
                    end
                end
                S_ELAP:    r_state <= S_CMP;
                S_CMP:     r_state <= S_BRANCH;
                S_BRANCH: begin
                    priority if (!i_status.close) begin
                        r_state <= S_HUND;
                    end else if (i_status.elapsed_zero) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_state <= S_MUL_LO;
                    end
                end
                S_MUL_LO:  r_state <= S_MUL_HI;
                S_MUL_HI:  r_state <= S_MUL_SUM;
                S_MUL_SUM: r_state <= S_OVF;
                S_OVF: begin
                    r_shift <= SHIFT_W'(QUO_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_shift == '0) begin
                        r_state <= S_ROUND;
                    end else begin
                        r_shift <= r_shift - SHIFT_W'(1);
                    end
                end
                S_ROUND:   r_state <= S_COMMIT;
                S_COMMIT:  r_state <= S_HUND;
                S_HUND:    r_state <= S_REM;
                S_REM:     r_state <= S_TENS;
                S_TENS:    r_state <= S_ONES;
                S_ONES:    r_state <= S_EMIT;
                S_EMIT: begin
                    if (emit_ok) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default:   r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/frame_rate_meter.sv =====
// sequence: an accepted present takes the elapsed and compare steps, then the digit
//   steps; a closing window with no elapsed ticks adds commit, a recomputed rate adds
//   multiply, divide, round and commit; one present at a time through the shared
//   multiplier and divider; a stalled readout holds the next one before its hand-off
// reset (synchronous, active low): window unseeded, count and held rate zero,
//   ticks_per_second 19200000, overlay off, no result pending
// ----------------------------------------------------------------------------
// frame_rate_meter
// windowed frame rate counter: counts presents over one second of ticks and
// reports the rounded rate, its decimal digits and the overlay enable
// ----------------------------------------------------------------------------
module frame_rate_meter import frm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    frm_frame_if.sink             i_frame,
    frm_rate_if.source            o_rate,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // command and status between sequencer and datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_result    result;
    logic       in_ready;
    logic       out_valid;

    // sequencer: takes a transaction only when idle, holds the result register
    // valid until the downstream side takes it, so the next present can start
    // while an earlier readout still waits
    frm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_frame.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rate.ready),
        .o_out_valid (out_valid),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // datapath: window state, frame count, rate arithmetic and result register
    frm_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_present_tick (i_frame.present_tick),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_result       (result)
    );

    assign i_frame.ready = in_ready;

    // readout transaction
    assign o_rate.valid          = out_valid;
    assign o_rate.frame_rate     = result.frame_rate;
    assign o_rate.digit_hundreds = result.digit_hundreds;
    assign o_rate.digit_tens     = result.digit_tens;
    assign o_rate.digit_ones     = result.digit_ones;
    assign o_rate.digit_count    = result.digit_count;
    assign o_rate.rate_updated   = result.rate_updated;
    assign o_rate.overlay_shown  = result.overlay_shown;

endmodule

// ===== hw/rtl/frm_checker.sv =====
// ----------------------------------------------------------------------------
// frm_checker
// port-level checks of the frame rate meter, bound to the top level
// ----------------------------------------------------------------------------
module frm_checker import frm_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [RATE_W-1:0]   i_frame_rate,
    input logic [DIGIT_W-1:0]  i_digit_hundreds,
    input logic [DIGIT_W-1:0]  i_digit_tens,
    input logic [DIGIT_W-1:0]  i_digit_ones,
    input logic [DCOUNT_W-1:0] i_digit_count,
    input logic                i_rate_updated
);

    // a stalled readout holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frame_rate)
            && $stable(i_rate_updated))
        else $error("readout changed while stalled");

    // rate in range and digits add up to it
    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_frame_rate <= RATE_MAX
            && RATE_W'(i_digit_hundreds) * DEC_100 + RATE_W'(i_digit_tens) * DEC_10
               + RATE_W'(i_digit_ones) == i_frame_rate)
        else $error("decimal digits do not match frame rate");

    // digit count follows the magnitude
    a_dcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_frame_rate >= DEC_100 && i_digit_count == DCOUNT_THREE)
            || (i_frame_rate < DEC_100 && i_frame_rate >= DEC_10
                && i_digit_count == DCOUNT_TWO)
            || (i_frame_rate < DEC_10 && i_digit_count == DCOUNT_ONE))
        else $error("digit count does not match frame rate");

    // one present at a time: busy right after a transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("present taken while previous one in progress");

endmodule

bind frame_rate_meter frm_checker u_frm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_frame.valid),
    .i_in_ready       (i_frame.ready),
    .i_out_valid      (o_rate.valid),
    .i_out_ready      (o_rate.ready),
    .i_frame_rate     (o_rate.frame_rate),
    .i_digit_hundreds (o_rate.digit_hundreds),
    .i_digit_tens     (o_rate.digit_tens),
    .i_digit_ones     (o_rate.digit_ones),
    .i_digit_count    (o_rate.digit_count),
    .i_rate_updated   (o_rate.rate_updated)
);
